[src/dtf_pkg.sv]
// ---------------------------------------------------------------------------
// dtf_pkg
// shared constants for the decimal text to float converter: multiplier
// operand selects, float constants and parse defaults
// ---------------------------------------------------------------------------
package dtf_pkg;

  localparam int DTF_MAX_DIGITS  = 8;
  localparam int DTF_COUNT_LIMIT = 255;

  // constant operand select for the shared multiplier
  localparam logic [1:0] K_HUNDREDTH = 2'd0;
  localparam logic [1:0] K_TENTH     = 2'd1;
  localparam logic [1:0] K_TEN       = 2'd2;

  // biased exponent and 24-bit significand of 0.01f, 0.1f and 10.0f
  localparam logic [7:0]  EXP_HUNDREDTH = 8'd120;
  localparam logic [23:0] MAN_HUNDREDTH = 24'hA3D70A;
  localparam logic [7:0]  EXP_TENTH     = 8'd123;
  localparam logic [23:0] MAN_TENTH     = 24'hCCCCCD;
  localparam logic [7:0]  EXP_TEN       = 8'd130;
  localparam logic [23:0] MAN_TEN       = 24'hA00000;

  localparam logic [31:0] FLOAT_INF = 32'h7F800000;

endpackage

[src/dtf_fmul.sv]
// ---------------------------------------------------------------------------
// dtf_fmul
// two-stage single precision multiply of a non-negative float by one of
// three constants, round to nearest even, subnormal and overflow aware
// ---------------------------------------------------------------------------
module dtf_fmul
  import dtf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [1:0]  sel,
  output logic        done,
  output logic [31:0] y
);

  logic [7:0]         eb;
  logic [23:0]        mb;
  logic [7:0]         ea;
  logic [23:0]        ma;
  logic               v1_r, v2_r;
  logic [47:0]        p_r;
  logic signed [10:0] epre_r;
  logic               inf_r, zero_r;
  logic [31:0]        y_r;

  always_comb begin
    case (sel)
      K_HUNDREDTH: begin eb = EXP_HUNDREDTH; mb = MAN_HUNDREDTH; end
      K_TENTH:     begin eb = EXP_TENTH;     mb = MAN_TENTH;     end
      K_TEN:       begin eb = EXP_TEN;       mb = MAN_TEN;       end
      default:     begin eb = EXP_TEN;       mb = MAN_TEN;       end
    endcase
    if (a[30:23] == 8'd0) begin
      ea = 8'd1;
      ma = {1'b0, a[22:0]};
    end else begin
      ea = a[30:23];
      ma = {1'b1, a[22:0]};
    end
  end

  // stage 1: significand product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
    if (start) begin
      p_r    <= ma * mb;
      epre_r <= $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd127;
      inf_r  <= (a[30:23] == 8'hFF);
      zero_r <= (a[30:0] == 31'd0);
    end
  end

  // stage 2: normalize, denormalize, round
  logic [47:0]        q, sh;
  logic signed [10:0] e;
  logic [5:0]         s;
  logic               lost, g, st, inc;
  logic [7:0]         ef;
  logic [31:0]        rnd;

  always_comb begin
    if (p_r[47]) begin
      q = p_r;
      e = epre_r + 11'sd1;
    end else begin
      q = {p_r[46:0], 1'b0};
      e = epre_r;
    end
    s = 6'd0;
    if (e <= 11'sd0) begin
      s = ((11'sd1 - e) > 11'sd48) ? 6'd48 : 6'(11'sd1 - e);
    end
    sh   = q >> s;
    lost = |(q & ~({48{1'b1}} << s));
    g    = sh[23];
    st   = (|sh[22:0]) | lost;
    inc  = g & (st | sh[24]);
    ef   = (e <= 11'sd0) ? 8'd0 : e[7:0];
    rnd  = {1'b0, ef, sh[46:24]} + {31'd0, inc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    if (v1_r) begin
      if (inf_r || e >= 11'sd255) begin
        y_r <= FLOAT_INF;
      end else if (zero_r) begin
        y_r <= 32'd0;
      end else begin
        y_r <= rnd;
      end
    end
  end

  assign done = v2_r;
  assign y    = y_r;

endmodule

[src/dtf_i2f.sv]
// ---------------------------------------------------------------------------
// dtf_i2f
// unsigned integer to single precision, normalized one bit per cycle,
// then rounded to nearest even
// ---------------------------------------------------------------------------
module dtf_i2f
  import dtf_pkg::*;
#(
  parameter int ACC_W = 27
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ACC_W-1:0] m,
  output logic             done,
  output logic [31:0]      y
);

  localparam int NW = ACC_W + 25;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [7:0]    e_r, e_nxt;
  logic [31:0]   y_r, y_nxt;
  logic [23:0]   mant;
  logic          g, st, inc;

  always_comb begin
    mant     = n_r[NW-1 -: 24];
    g        = n_r[NW-25];
    st       = |n_r[NW-26:0];
    inc      = g & (st | mant[0]);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    n_nxt    = n_r;
    e_nxt    = e_r;
    y_nxt    = y_r;
    if (start) begin
      busy_nxt = 1'b1;
      n_nxt    = {m, 25'd0};
      e_nxt    = 8'(127 + ACC_W - 1);
    end else if (busy_r) begin
      if (!n_r[NW-1]) begin
        n_nxt = {n_r[NW-2:0], 1'b0};
        e_nxt = e_r - 8'd1;
      end else begin
        y_nxt    = {1'b0, e_r, mant[22:0]} + {31'd0, inc};
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    n_r <= n_nxt;
    e_r <= e_nxt;
    y_r <= y_nxt;
  end

  assign done = done_r;
  assign y    = y_r;

endmodule

[src/decimal_text_to_float_core.sv]
// a leading sign, a digit or a point is taken as it arrives; a terminator starts
// integer normalization, then the scaling multiplies (up to 127 multiplies by
// ten), and the result then goes to the output register
// throughput: one character per cycle while parsing, the shared multiplier
// sets the terminator time; reset (synchronous, rst_n low) clears all control state
// ---------------------------------------------------------------------------
// decimal_text_to_float_core
// streaming decimal text parser with an iterative float scaling sequencer
// ---------------------------------------------------------------------------
module decimal_text_to_float_core
  import dtf_pkg::*;
#(
  parameter int MAX_DIGITS  = DTF_MAX_DIGITS,
  parameter int COUNT_LIMIT = DTF_COUNT_LIMIT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [0] ok, [32:1] value_bits, [40:33] chars_used
);

  localparam int ACC_W = $clog2(10 ** MAX_DIGITS);
  localparam int CW    = $clog2(COUNT_LIMIT + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SEL  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]        st_r, st_nxt;
  logic              first_r, first_nxt;
  logic              neg_r, neg_nxt;
  logic              pt_r, pt_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [7:0]        dc_r, dc_nxt;
  logic signed [7:0] dexp_r, dexp_nxt;
  logic [CW-1:0]     cons_r, cons_nxt;
  logic [31:0]       f_r, f_nxt;
  logic              ov_r, ov_nxt;
  logic [47:0]       od_r, od_nxt;

  logic              i2f_start, i2f_done;
  logic [31:0]       i2f_y;
  logic              fm_start, fm_done;
  logic [1:0]        fm_sel;
  logic [31:0]       fm_y;

  logic              acc_beat, is_digit;
  logic [ACC_W+3:0]  acc10;
  logic [CW-1:0]     cons_inc;
  logic [CW+7:0]     cext;
  logic [7:0]        used;

  assign in_tready = (st_r == S_IDLE);
  assign acc_beat  = in_tvalid && in_tready;
  assign is_digit  = (in_tdata >= 8'h30) && (in_tdata <= 8'h39);
  assign acc10     = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1)
                     + {(ACC_W)'(0), in_tdata[3:0]};
  assign cons_inc  = (cons_r < CW'(COUNT_LIMIT)) ? cons_r + CW'(1) : cons_r;
  assign cext      = {8'd0, cons_r};
  assign used      = (cext > (CW+8)'(255)) ? 8'hFF : cext[7:0];

  always_comb begin
    st_nxt    = st_r;
    first_nxt = first_r;
    neg_nxt   = neg_r;
    pt_nxt    = pt_r;
    acc_nxt   = acc_r;
    dc_nxt    = dc_r;
    dexp_nxt  = dexp_r;
    cons_nxt  = cons_r;
    f_nxt     = f_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    i2f_start = 1'b0;
    fm_start  = 1'b0;
    fm_sel    = K_TEN;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      S_IDLE: begin
        if (acc_beat) begin
          first_nxt = 1'b0;
          if (first_r && (in_tdata == 8'h2D || in_tdata == 8'h2B)) begin
            neg_nxt  = (in_tdata == 8'h2D);
            cons_nxt = cons_inc;
          end else if (is_digit) begin
            cons_nxt = cons_inc;
            if (dc_r != 8'hFF) begin
              dc_nxt = dc_r + 8'd1;
            end
            if (dc_r < 8'(MAX_DIGITS)) begin
              if (pt_r && dexp_r != -8'sd128) begin
                dexp_nxt = dexp_r - 8'sd1;
              end
              acc_nxt = acc10[ACC_W-1:0];
            end else if (!pt_r && dexp_r != 8'sd127) begin
              dexp_nxt = dexp_r + 8'sd1;
            end
          end else if (in_tdata == 8'h2E && !pt_r) begin
            cons_nxt = cons_inc;
            pt_nxt   = 1'b1;
          end else if (dc_r == 8'd0 || acc_r == '0) begin
            // no digits, or a zero value that skips scaling
            f_nxt  = 32'd0;
            st_nxt = S_OUT;
          end else begin
            i2f_start = 1'b1;
            st_nxt    = S_CONV;
          end
        end
      end
      S_CONV: begin
        if (i2f_done) begin
          f_nxt  = i2f_y;
          st_nxt = S_SEL;
        end
      end
      S_SEL: begin
        if (dexp_r <= -8'sd2) begin
          fm_start = 1'b1;
          fm_sel   = K_HUNDREDTH;
          dexp_nxt = dexp_r + 8'sd2;
          st_nxt   = S_WAIT;
        end else if (dexp_r == -8'sd1) begin
          fm_start = 1'b1;
          fm_sel   = K_TENTH;
          dexp_nxt = 8'sd0;
          st_nxt   = S_WAIT;
        end else if (dexp_r > 8'sd0) begin
          fm_start = 1'b1;
          fm_sel   = K_TEN;
          dexp_nxt = dexp_r - 8'sd1;
          st_nxt   = S_WAIT;
        end else begin
          st_nxt = S_OUT;
        end
      end
      S_WAIT: begin
        if (fm_done) begin
          f_nxt  = fm_y;
          st_nxt = S_SEL;
        end
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          if (dc_r == 8'd0) begin
            od_nxt = 48'd0;
          end else begin
            od_nxt = {7'd0, used, neg_r, f_r[30:0], 1'b1};
          end
          first_nxt = 1'b1;
          neg_nxt   = 1'b0;
          pt_nxt    = 1'b0;
          acc_nxt   = '0;
          dc_nxt    = 8'd0;
          dexp_nxt  = 8'sd0;
          cons_nxt  = '0;
          st_nxt    = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      first_r <= 1'b1;
      neg_r   <= 1'b0;
      pt_r    <= 1'b0;
      acc_r   <= '0;
      dc_r    <= 8'd0;
      dexp_r  <= 8'sd0;
      cons_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      first_r <= first_nxt;
      neg_r   <= neg_nxt;
      pt_r    <= pt_nxt;
      acc_r   <= acc_nxt;
      dc_r    <= dc_nxt;
      dexp_r  <= dexp_nxt;
      cons_r  <= cons_nxt;
      ov_r    <= ov_nxt;
    end
    f_r  <= f_nxt;
    od_r <= od_nxt;
  end

  dtf_i2f #(
    .ACC_W (ACC_W)
  ) u_i2f (
    .clk   (clk),
    .rst_n (rst_n),
    .start (i2f_start),
    .m     (acc_r),
    .done  (i2f_done),
    .y     (i2f_y)
  );

  dtf_fmul u_fmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fm_start),
    .a     (f_r),
    .sel   (fm_sel),
    .done  (fm_done),
    .y     (fm_y)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

`ifndef SYNTHESIS
  a_fm_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    fm_start |-> st_r == S_SEL && !fm_done)
    else $error("multiplier issued while busy");
  a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !od_r[0]) |-> od_r[40:1] == 40'd0)
    else $error("failed parse with nonzero payload");
  a_compute_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CONV || st_r == S_WAIT || st_r == S_SEL) |-> dc_r != 8'd0)
    else $error("scaling without digits");
`endif

endmodule
